>>> rtl/dense_layer_mac_with_reward_update_macros.svh
// Assertion macros shared by the dense layer MAC block.
// Included by every RTL file that carries concurrent assertions.
`ifndef DENSE_LAYER_MAC_WITH_REWARD_UPDATE_MACROS_SVH
`define DENSE_LAYER_MAC_WITH_REWARD_UPDATE_MACROS_SVH
`ifndef SYNTH
`define DLMR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property violated");
`define DLMR_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define DLMR_ASSERT(lbl, clk, rst, prop)
`define DLMR_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> rtl/dlmr_pkg.sv
// Types and constants of the dense layer MAC block.
// Used by the controller, the datapath and the top level.
`default_nettype none
package dlmr_pkg;
   typedef enum logic [2:0] {
      CMD_LOAD  = 3'd0,
      CMD_ADD   = 3'd1,
      CMD_TICK  = 3'd2,
      CMD_LEARN = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_SUM  = 2'd0,
      KIND_PROP = 2'd1,
      KIND_READ = 2'd2
   } kind_type;

   localparam logic CSR_ACTIVE_INPUTS = 1'b0;
   localparam logic CSR_ACTIVE_ROWS   = 1'b1;

   localparam int SQRT_STEPS   = 23;
   localparam int DIV_STEPS    = 16;
   localparam int DRAIN_CYCLES = 2;
   localparam int SUM_W        = 38;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_ADD_RD, ST_ADD_WR, ST_RD_ISSUE, ST_RD_OUT,
      ST_T_RUN, ST_T_DRAIN, ST_T_EMIT,
      ST_L_RD0, ST_L_W0, ST_L_MUL, ST_L_SQRT, ST_L_DELTA, ST_L_INC, ST_L_DIV,
      ST_L_RD, ST_L_WR, ST_L_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic w_we;
      logic w_re;
      logic learn_wr;
      logic in_we;
      logic in_re;
      logic mac_issue;
      logic acc_clear;
      logic clear_inputs;
      logic learn_w0;
      logic learn_mul;
      logic sqrt_step;
      logic learn_delta;
      logic learn_inc;
      logic div_step;
      logic emit_sum;
      logic emit_prop;
      logic emit_read;
      logic last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;
endpackage
`default_nettype wire

>>> rtl/dlmr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module dlmr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                         wdata,
   input  wire logic                                     re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> rtl/dlmr_ctrl.sv
// Controller of the dense layer MAC block: command sequencing, counters and
// configuration registers. Depends on dlmr_pkg.
`default_nettype none
module dlmr_ctrl #(
   parameter int MAX_ROWS   = 16,
   parameter int MAX_INPUTS = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [2:0]                  req_cmd,
   input  wire logic [3:0]                  req_row,
   input  wire logic [5:0]                  req_col,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [6:0]                  csr_data,
   input  wire dlmr_pkg::dp_status_type     status,
   output dlmr_pkg::dp_cmd_type             cmd,
   output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]     row,
   output logic [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0] col,
   output logic [$clog2(MAX_INPUTS+1)-1:0]  ni
);
   import dlmr_pkg::*;

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int NIW = $clog2(MAX_INPUTS + 1);
   localparam int NRW = $clog2(MAX_ROWS + 1);

   state_type      state_ff, state_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [6:0]     ai_ff;
   logic [4:0]     ar_ff;
   logic [NRW-1:0] nr;
   logic           row_ok, col_ok, col_last, row_last;

   // Out-of-range register values clamp to one and to the store size.
   always_comb begin
      if (ai_ff == '0) begin
         ni = NIW'(1);
      end else if (int'(ai_ff) > MAX_INPUTS) begin
         ni = NIW'(MAX_INPUTS);
      end else begin
         ni = NIW'(ai_ff);
      end
      if (ar_ff == '0) begin
         nr = NRW'(1);
      end else if (int'(ar_ff) > MAX_ROWS) begin
         nr = NRW'(MAX_ROWS);
      end else begin
         nr = NRW'(ar_ff);
      end
   end

   assign row_ok   = int'(req_row) < MAX_ROWS;
   assign col_ok   = int'(req_col) < MAX_INPUTS;
   assign col_last = ((NIW+1)'(col_ff) + (NIW+1)'(1)) == (NIW+1)'(ni);
   assign row_last = ((NRW+1)'(row_ff) + (NRW+1)'(1)) == (NRW+1)'(nr);
   assign csr_ready = 1'b1;
   assign row = row_ff;
   assign col = col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ai_ff    <= 7'd64;
         ar_ff    <= 5'd16;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            if (csr_index == CSR_ACTIVE_INPUTS) begin
               ai_ff <= csr_data;
            end else begin
               ar_ff <= csr_data[4:0];
            end
         end
      end
      row_ff <= row_in;
      col_ff <= col_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               row_in      = RW'(req_row);
               col_in      = CW'(req_col);
               unique case (cmd_type'(req_cmd))
                  CMD_LOAD: begin
                     if (row_ok && col_ok) state_in = ST_LOAD;
                  end
                  CMD_ADD: begin
                     if (col_ok) state_in = ST_ADD_RD;
                  end
                  CMD_TICK: begin
                     row_in        = '0;
                     col_in        = '0;
                     cmd.acc_clear = 1'b1;
                     state_in      = ST_T_RUN;
                  end
                  CMD_LEARN: begin
                     col_in = '0;
                     if (row_ok) state_in = ST_L_RD0;
                  end
                  CMD_READ: begin
                     if (row_ok && col_ok) state_in = ST_RD_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.w_we = 1'b1;
            state_in = ST_IDLE;
         end
         ST_ADD_RD: begin
            cmd.in_re = 1'b1;
            state_in  = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cmd.in_we = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_RD_ISSUE: begin
            cmd.w_re = 1'b1;
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            if (status.out_free) begin
               cmd.emit_read = 1'b1;
               cmd.last      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_T_RUN: begin
            cmd.w_re      = 1'b1;
            cmd.in_re     = 1'b1;
            cmd.mac_issue = 1'b1;
            if (col_last) begin
               cnt_in   = '0;
               state_in = ST_T_DRAIN;
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_T_DRAIN: begin
            if (cnt_ff == 5'(DRAIN_CYCLES - 1)) begin
               state_in = ST_T_EMIT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_T_EMIT: begin
            if (status.out_free) begin
               cmd.emit_sum  = 1'b1;
               cmd.last      = row_last;
               cmd.acc_clear = 1'b1;
               if (row_last) begin
                  cmd.clear_inputs = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  row_in   = row_ff + RW'(1);
                  col_in   = '0;
                  state_in = ST_T_RUN;
               end
            end
         end
         ST_L_RD0: begin
            cmd.w_re = 1'b1;
            state_in = ST_L_W0;
         end
         ST_L_W0: begin
            cmd.learn_w0 = 1'b1;
            state_in     = ST_L_MUL;
         end
         ST_L_MUL: begin
            cmd.learn_mul = 1'b1;
            cnt_in        = '0;
            state_in      = ST_L_SQRT;
         end
         ST_L_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == 5'(SQRT_STEPS - 1)) begin
               state_in = ST_L_DELTA;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_L_DELTA: begin
            cmd.learn_delta = 1'b1;
            state_in        = ST_L_INC;
         end
         ST_L_INC: begin
            cmd.learn_inc = 1'b1;
            cnt_in        = '0;
            state_in      = ST_L_DIV;
         end
         ST_L_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_L_RD;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_L_RD: begin
            cmd.w_re = 1'b1;
            state_in = ST_L_WR;
         end
         ST_L_WR: begin
            cmd.w_we     = 1'b1;
            cmd.learn_wr = 1'b1;
            if (col_last) begin
               state_in = ST_L_OUT;
            end else begin
               col_in   = col_ff + CW'(1);
               state_in = ST_L_RD;
            end
         end
         ST_L_OUT: begin
            if (status.out_free) begin
               cmd.emit_prop = 1'b1;
               cmd.last      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> rtl/dlmr_dpath.sv
// Datapath of the dense layer MAC block: weight and input RAMs, MAC pipeline,
// square root and divider units, result register. Depends on dlmr_pkg, dlmr_ram.
`default_nettype none
module dlmr_dpath #(
   parameter int MAX_ROWS   = 16,
   parameter int MAX_INPUTS = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dlmr_pkg::dp_cmd_type        cmd,
   output dlmr_pkg::dp_status_type          status,
   input  wire logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]     row,
   input  wire logic [((MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1)-1:0] col,
   input  wire logic [$clog2(MAX_INPUTS+1)-1:0] ni,
   input  wire logic [15:0]                 req_weight,
   input  wire logic [15:0]                 req_value,
   input  wire logic [15:0]                 req_reward,
   input  wire logic [15:0]                 req_scale,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [1:0]                       rsp_kind,
   output logic [3:0]                       rsp_row,
   output logic [37:0]                      rsp_sum,
   output logic [15:0]                      rsp_prop,
   output logic [15:0]                      rsp_wout,
   output logic                             rsp_last
);
   import dlmr_pkg::*;

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int NIW   = $clog2(MAX_INPUTS + 1);
   localparam int ACC_W = 32 + CW;
   localparam longint SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
   localparam longint SUM_MIN = -SUM_MAX - 64'sd1;

   function automatic logic [15:0] sat16(input logic signed [21:0] v);
      if (v > 22'sd32767) return 16'h7FFF;
      if (v < -22'sd32768) return 16'h8000;
      return v[15:0];
   endfunction

   logic signed [15:0] wt_ff, val_ff, rew_ff;
   logic        [15:0] scale_ff;
   logic        [15:0] w_rdata, in_rdata, w_wdata, in_wdata;
   logic [(1 << CW)-1:0] valid_ff;
   logic               in_rvalid_ff;
   logic signed [15:0] in_val, w_val;

   logic               v1_ff, v2_ff;
   logic signed [31:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [63:0] acc64;
   logic        [37:0] sum_sat;

   logic        [15:0] a_ff, rabs;
   logic        [30:0] rr_ff;
   logic               neg_ff;
   logic        [45:0] rem_ff, res_ff, bit_ff, trial;
   logic        [17:0] m;
   logic        [15:0] dmag_ff;
   logic               dneg_ff;
   logic        [19:0] inc_mag;
   logic signed [20:0] inc_ff;
   logic        [15:0] dq_ff;
   logic     [NIW-1:0] drem_ff;
   logic       [NIW:0] dtry;
   logic        [15:0] prop;

   logic               out_valid_ff;
   logic         [1:0] out_kind_ff;
   logic         [3:0] out_row_ff;
   logic        [37:0] out_sum_ff;
   logic        [15:0] out_prop_ff, out_wout_ff;
   logic               out_last_ff;

   assign in_val  = in_rvalid_ff ? $signed(in_rdata) : 16'sd0;
   assign w_val   = $signed(w_rdata);
   assign in_wdata = sat16(22'(in_val) + 22'(val_ff));
   assign w_wdata  = cmd.learn_wr ? sat16(22'(w_val) + 22'(inc_ff)) : wt_ff;

   dlmr_ram #(.WIDTH(16), .DEPTH(1 << (RW + CW))) u_wram (
      .clock (clock),
      .we    (cmd.w_we),
      .waddr ({row, col}),
      .wdata (w_wdata),
      .re    (cmd.w_re),
      .raddr ({row, col}),
      .rdata (w_rdata)
   );

   dlmr_ram #(.WIDTH(16), .DEPTH(1 << CW)) u_iram (
      .clock (clock),
      .we    (cmd.in_we),
      .waddr (col),
      .wdata (in_wdata),
      .re    (cmd.in_re),
      .raddr (col),
      .rdata (in_rdata)
   );

   // Input elements never written since reset, or since the last tick for those below ni, read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.in_we) valid_ff[col] <= 1'b1;
         if (cmd.clear_inputs) begin
            for (int i = 0; i < (1 << CW); i++) begin
               if (i < int'(ni)) valid_ff[i] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         wt_ff    <= req_weight;
         val_ff   <= req_value;
         rew_ff   <= req_reward;
         scale_ff <= req_scale;
      end
      if (cmd.in_re) in_rvalid_ff <= valid_ff[col];
   end

   // MAC pipeline: RAM read, product register, accumulator.
   assign acc64 = 64'(acc_ff);
   always_comb begin
      if (acc64 > SUM_MAX) sum_sat = SUM_W'(SUM_MAX);
      else if (acc64 < SUM_MIN) sum_sat = SUM_W'(SUM_MIN);
      else sum_sat = acc64[37:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
      if (v1_ff) prod_ff <= in_val * w_val;
      if (cmd.acc_clear) acc_ff <= '0;
      else if (v2_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
   end

   // Learn: m = (isqrt(R*R*|w0|) + 32) >> 6, one root digit per step.
   assign rabs  = rew_ff[15] ? 16'(-rew_ff) : 16'(rew_ff);
   assign trial = res_ff + bit_ff;
   assign m     = 18'((res_ff + 46'd32) >> 6);
   assign inc_mag = 20'((32'(dmag_ff) * 32'(scale_ff) + 32'd2048) >> 12);
   assign dtry  = {drem_ff, dq_ff[15]};
   assign prop  = dneg_ff ? 16'(-dq_ff) : dq_ff;

   always_ff @(posedge clock) begin
      if (cmd.learn_w0) begin
         a_ff   <= w_val[15] ? 16'(-w_val) : 16'(w_val);
         rr_ff  <= 31'(32'(rabs) * 32'(rabs));
         neg_ff <= rew_ff[15] != w_val[15];
      end
      if (cmd.learn_mul) begin
         rem_ff <= 46'(47'(rr_ff) * 47'(a_ff));
         res_ff <= '0;
         bit_ff <= 46'(1) << 44;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.learn_delta) begin
         if (m == '0) begin
            dmag_ff <= '0;
            dneg_ff <= 1'b0;
         end else if (neg_ff) begin
            dmag_ff <= (m > 18'd32768) ? 16'h8000 : m[15:0];
            dneg_ff <= 1'b1;
         end else begin
            dmag_ff <= (m > 18'd32767) ? 16'h7FFF : m[15:0];
            dneg_ff <= 1'b0;
         end
      end
      if (cmd.learn_inc) begin
         inc_ff  <= dneg_ff ? -$signed(21'(inc_mag)) : $signed(21'(inc_mag));
         dq_ff   <= dmag_ff;
         drem_ff <= '0;
      end else if (cmd.div_step) begin
         if (dtry >= (NIW+1)'(ni)) begin
            drem_ff <= NIW'(dtry - (NIW+1)'(ni));
            dq_ff   <= {dq_ff[14:0], 1'b1};
         end else begin
            drem_ff <= NIW'(dtry);
            dq_ff   <= {dq_ff[14:0], 1'b0};
         end
      end
   end

   // Result register; it reloads in the cycle its contents are taken.
   assign status.out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_sum || cmd.emit_prop || cmd.emit_read) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit_sum || cmd.emit_prop || cmd.emit_read) begin
         out_row_ff  <= 4'(row);
         out_last_ff <= cmd.last;
         out_sum_ff  <= cmd.emit_sum ? sum_sat : '0;
         out_prop_ff <= cmd.emit_prop ? prop : '0;
         out_wout_ff <= cmd.emit_read ? w_rdata : '0;
         if (cmd.emit_sum) out_kind_ff <= KIND_SUM;
         else if (cmd.emit_prop) out_kind_ff <= KIND_PROP;
         else out_kind_ff <= KIND_READ;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_row    = out_row_ff;
   assign rsp_sum    = out_sum_ff;
   assign rsp_prop   = out_prop_ff;
   assign rsp_wout   = out_wout_ff;
   assign rsp_last   = out_last_ff;
endmodule
`default_nettype wire

>>> rtl/dense_layer_mac_with_reward_update.sv
// Dense layer MAC block with reward-driven learning: controller plus datapath.
// Depends on dlmr_pkg, dlmr_ctrl, dlmr_dpath and the assertion macro header.
//
// Usage: one command transaction on the req_ channel (command in req_tuser)
// yields zero or more result transactions on the rsp_ channel. Commands are
// taken one at a time; req_tready is high only while the block is idle.
// The tick is bound by the single multiply-accumulate unit, one weight per
// cycle; learn by the root and divider units, one digit per cycle, and the
// weight RAM port. A result sits in an output register; while the receiver
// stalls the block holds at its next result and resumes once the register
// is taken.
// Reset empties the input vector (reads as zero), sets active inputs to 64
// and active rows to 16 and drops any pending result. Weights are undefined
// until loaded. The csr_ channel is always ready; write it only while idle.
`default_nettype none
`include "dense_layer_mac_with_reward_update_macros.svh"
module dense_layer_mac_with_reward_update #(
   parameter int MAX_ROWS   = 16,
   parameter int MAX_INPUTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] row_index, [9:4] col_index, [25:10] weight_in, [41:26] input_value,
   // [57:42] reward, [73:58] learn_scale, [79:74] zero
   input  wire logic [79:0] req_tdata,
   // [2:0] command
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] row_out, [41:4] row_sum, [57:42] propagated_reward,
   // [73:58] weight_out, [79:74] zero
   output logic [79:0]      rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);
   import dlmr_pkg::*;

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int NIW = $clog2(MAX_INPUTS + 1);

   dp_cmd_type     cmd;
   dp_status_type  status;
   logic [RW-1:0]  row;
   logic [CW-1:0]  col;
   logic [NIW-1:0] ni;
   logic [3:0]     rsp_row;
   logic [37:0]    rsp_sum;
   logic [15:0]    rsp_prop, rsp_wout;

   dlmr_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_INPUTS(MAX_INPUTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .req_row    (req_tdata[3:0]),
      .req_col    (req_tdata[9:4]),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .status     (status),
      .cmd        (cmd),
      .row        (row),
      .col        (col),
      .ni         (ni)
   );

   dlmr_dpath #(.MAX_ROWS(MAX_ROWS), .MAX_INPUTS(MAX_INPUTS)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .row        (row),
      .col        (col),
      .ni         (ni),
      .req_weight (req_tdata[25:10]),
      .req_value  (req_tdata[41:26]),
      .req_reward (req_tdata[57:42]),
      .req_scale  (req_tdata[73:58]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_row    (rsp_row),
      .rsp_sum    (rsp_sum),
      .rsp_prop   (rsp_prop),
      .rsp_wout   (rsp_wout),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, rsp_wout, rsp_prop, rsp_sum, rsp_row};

   `DLMR_ASSERT(a_one_emit, clock, reset, $onehot0({cmd.emit_sum, cmd.emit_prop, cmd.emit_read}))
   `DLMR_ASSERT(a_emit_free, clock, reset, (cmd.emit_sum || cmd.emit_prop || cmd.emit_read) |-> status.out_free)
   `DLMR_ASSERT(a_single_last, clock, reset, (rsp_tvalid && (rsp_tuser != KIND_SUM)) |-> rsp_tlast)
   `DLMR_ASSERT(a_tick_idle, clock, reset, cmd.clear_inputs |=> req_tready)
   `DLMR_NEVER(a_mac_no_write, clock, reset, cmd.mac_issue && (cmd.w_we || cmd.in_we))
endmodule
`default_nettype wire
